>>> rtl/core/bitmap_range_ops_with_run_query_unit_macros.svh
// Assertion macros used by the checker file of the bitmap range unit.
`ifndef BITMAP_RANGE_OPS_WITH_RUN_QUERY_UNIT_MACROS_SVH
`define BITMAP_RANGE_OPS_WITH_RUN_QUERY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/brq_pkg.sv
// Package with the widths, operation codes and shared types of the bitmap range unit.
`default_nettype none
package brq_pkg;

   localparam int BITS       = 1024;
   localparam int DIGIT      = 8;
   localparam int NUM_DIGITS = BITS / DIGIT;
   localparam int DIGIT_LOG  = $clog2(DIGIT);
   localparam int DCNT_W     = $clog2(NUM_DIGITS);
   localparam int POS_W      = $clog2(BITS);
   localparam int OP_W       = 3;
   localparam int INDEX_W    = 10;
   localparam int RESULT_W   = 11;
   localparam int CMP_W      = (POS_W > INDEX_W) ? POS_W : INDEX_W;

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET    = 3'd1;
   localparam logic [OP_W-1:0] OP_INVERT = 3'd2;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
   localparam logic [OP_W-1:0] OP_RUN    = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CMP_W-1:0] lo;
      logic [CMP_W-1:0] hi;
      logic             empty;
   } scan_ctrl_type;

   typedef struct packed {
      logic [RESULT_W-1:0] count;
      logic [RESULT_W-1:0] run;
      logic [RESULT_W-1:0] best;
   } scan_acc_type;

endpackage
`default_nettype wire

>>> rtl/core/brq_if.sv
// Valid/ready channel interfaces for the request and response items.
`default_nettype none
interface brq_req_if import brq_pkg::*;;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [INDEX_W-1:0] first_index;
   logic [INDEX_W-1:0] last_index;

   modport source (output valid, output operation, output first_index,
                   output last_index, input ready);
   modport sink   (input valid, input operation, input first_index,
                   input last_index, output ready);
endinterface

interface brq_rsp_if import brq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] query_result;

   modport source (output valid, output query_result, input ready);
   modport sink   (input valid, input query_result, output ready);
endinterface
`default_nettype wire

>>> rtl/core/brq_digit_alu.sv
// Digit datapath: updates one digit of the bitmap and folds it into count and run.
`default_nettype none
module brq_digit_alu import brq_pkg::*; (
   input  scan_ctrl_type    ctrl,
   input  logic [POS_W-1:0] base,
   input  logic [DIGIT-1:0] digit_in,
   input  scan_acc_type     acc_in,
   output logic [DIGIT-1:0] digit_out,
   output scan_acc_type     acc_out
);

   logic [DIGIT-1:0] in_range;
   logic [CMP_W-1:0] pos;
   scan_acc_type     acc_v;

   always_comb begin
      pos = '0;
      for (int j = 0; j < DIGIT; j++) begin
         pos = CMP_W'(base) + CMP_W'(j);
         in_range[j] = !ctrl.empty && (pos >= ctrl.lo) && (pos <= ctrl.hi);
      end
   end

   always_comb begin
      digit_out = digit_in;
      for (int j = 0; j < DIGIT; j++) begin
         if (in_range[j]) begin
            case (ctrl.op)
               OP_CLEAR:  digit_out[j] = 1'b0;
               OP_SET:    digit_out[j] = 1'b1;
               OP_INVERT: digit_out[j] = ~digit_in[j];
               default:   digit_out[j] = digit_in[j];
            endcase
         end
      end
   end

   // Clear bits and bits outside the range break a run, so the run counter restarts there.
   always_comb begin
      acc_v = acc_in;
      for (int j = 0; j < DIGIT; j++) begin
         if (in_range[j] && digit_in[j]) begin
            acc_v.count = acc_v.count + RESULT_W'(1);
            acc_v.run   = acc_v.run + RESULT_W'(1);
            if (acc_v.run > acc_v.best) begin
               acc_v.best = acc_v.run;
            end
         end else begin
            acc_v.run = '0;
         end
      end
      acc_out = acc_v;
   end

endmodule
`default_nettype wire

>>> rtl/core/bitmap_range_ops_with_run_query_unit.sv
// An item is taken while the unit is idle, walked over all NUM_DIGITS digits (128 for 1024 bits),
// and a query result is then registered in the done state, which waits while a stalled
// result still holds the result register; no new item is taken until the unit is idle again.
// The bitmap ring rotates one 8-bit digit per cycle through the single digit datapath.
// Reset (synchronous, active high) clears the whole bitmap, the controller state and the
// result valid flag; the unit takes an item in the cycle after reset drops.
`default_nettype none
module bitmap_range_ops_with_run_query_unit import brq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   brq_req_if.sink   req,
   brq_rsp_if.source rsp
);

   // Controller states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // The bitmap lives in a ring of flip-flops. The lowest digit of the ring is the only one
   // the datapath sees; each scan cycle the ring shifts down by one digit and the updated
   // digit re-enters at the top. After NUM_DIGITS shifts every bit is back at its place.
   logic [BITS-1:0]     ring_ff, ring_in;
   logic [1:0]          state_ff, state_in;
   logic [DCNT_W-1:0]   digit_ff, digit_in;
   scan_ctrl_type       ctrl_ff, ctrl_in;
   scan_acc_type        acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_result_ff, rsp_result_in;

   logic [DIGIT-1:0]    alu_digit;
   scan_acc_type        alu_acc;
   logic [POS_W-1:0]    base_pos;
   logic [CMP_W-1:0]    lo_ext, hi_ext, hi_clip;
   logic                is_query;

   assign base_pos = {digit_ff, DIGIT_LOG'(0)};

   brq_digit_alu u_alu (
      .ctrl      (ctrl_ff),
      .base      (base_pos),
      .digit_in  (ring_ff[DIGIT-1:0]),
      .acc_in    (acc_ff),
      .digit_out (alu_digit),
      .acc_out   (alu_acc)
   );

   // The last index is clipped to the top of the bitmap; a reversed range is empty.
   assign lo_ext  = CMP_W'(req.first_index);
   assign hi_ext  = CMP_W'(req.last_index);
   assign hi_clip = (hi_ext > CMP_W'(BITS - 1)) ? CMP_W'(BITS - 1) : hi_ext;

   assign is_query = (ctrl_ff.op == OP_COUNT) || (ctrl_ff.op == OP_RUN);

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.query_result = rsp_result_ff;

   always_comb begin
      state_in      = state_ff;
      digit_in      = digit_ff;
      ctrl_in       = ctrl_ff;
      acc_in        = acc_ff;
      ring_in       = ring_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_result_in = rsp_result_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               // Every item, unknown codes too, takes a full walk; the datapath leaves
               // the bitmap alone for anything but the three update codes.
               ctrl_in.op    = req.operation;
               ctrl_in.lo    = lo_ext;
               ctrl_in.hi    = hi_clip;
               ctrl_in.empty = lo_ext > hi_clip;
               acc_in        = '0;
               digit_in      = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ring_in  = {alu_digit, ring_ff[BITS-1:DIGIT]};
            acc_in   = alu_acc;
            digit_in = digit_ff + DCNT_W'(1);
            if (digit_ff == DCNT_W'(NUM_DIGITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // A query waits here until the result register is free; updates leave at once.
            if (!is_query) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = (ctrl_ff.op == OP_COUNT) ? acc_ff.count : acc_ff.best;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ring_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_ff      <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff      <= digit_in;
      ctrl_ff       <= ctrl_in;
      acc_ff        <= acc_in;
      rsp_result_ff <= rsp_result_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/brq_checker.sv
// Port-level checker for the bitmap range unit and its bind statement.
`default_nettype none
`include "bitmap_range_ops_with_run_query_unit_macros.svh"
module brq_checker import brq_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [RESULT_W-1:0] rsp_query_result
);

   // A stalled result stays offered.
   `BRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

   // A stalled result keeps its value.
   `BRQ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_query_result), "rsp changed")

   // The unit works on one item at a time, so it is busy right after taking one.
   `BRQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   // A result never appears in the cycle right after an item is taken.
   `BRQ_ASSERT_IMPLY(a_no_early_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready), "early rsp")

endmodule

bind bitmap_range_ops_with_run_query_unit brq_checker u_brq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_query_result (rsp.query_result)
);
`default_nettype wire
